// ===== sv/curve_discount_factor_unit_macros.svh =====
// Assertion macros used by curve_discount_factor_unit.sv.
`ifndef CURVE_DISCOUNT_FACTOR_UNIT_MACROS_SVH
`define CURVE_DISCOUNT_FACTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CDF_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define CDF_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define CDF_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define CDF_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== sv/cdf_pkg.sv =====
package cdf_pkg;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } cdf_opcode_t;

    localparam logic [2:0] REG_NUM_POINTS = 3'd0;
    localparam logic [6:0] NUM_POINTS_RESET = 7'd1;

    localparam int DIV_NUM_W = 65;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_STEPS = DIV_NUM_W;

    localparam logic [51:0] LN2_Q52 = 52'hB17217F7D1CF8;
    localparam int K_BIAS = 48;
    localparam logic [57:0] BIAS_LN2 = 58'(K_BIAS) * 58'(LN2_Q52);
    localparam int TAYLOR_TERMS = 24;
    localparam logic [6:0] SHIFT_BASE = 7'(32 + K_BIAS);

    typedef struct packed
    {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } cdf_div_req_t;

endpackage

// ===== sv/cdf_div.sv =====
module cdf_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cdf_pkg::cdf_div_req_t              req,
    output logic                               done,
    output logic [cdf_pkg::DIV_NUM_W-1:0]      quotient
);
    import cdf_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [6:0]           cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            den_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/curve_discount_factor_unit.sv =====
// A load beat writes one (time, rate) point of the zero curve; a query beat returns
// exp(-(r(t) + shift) * t) in Q2.30 together with the shifted rate. The curve lookup
// uses the first point's rate for a time at or before the first point and the last
// point's rate for a time at or after the last. Otherwise it runs a binary search,
// then a final read and the interpolation. The exponential goes straight to the
// output when the exponent is clipped, or runs a range reduction and a Taylor series
// when it is in range. The shared 65-step restoring divider runs once for the
// interpolation quotient and once for each of the 24 Taylor terms, and that divider
// sets the query time. S_OUT then loads the output register. One beat is worked
// at a time; the input accepts again once the result sits in the output register. The
// curve memory is not cleared after reset, so every slot up to num_points minus one
// must be loaded first.
`include "curve_discount_factor_unit_macros.svh"

module curve_discount_factor_unit
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_index, point_time, point_rate, query_time, rate_shift, zero pad
    input  logic [135:0] s_axis_tdata,
    // opcode
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // discount_value, shifted_rate
    output logic [63:0]  m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cdf_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [21:0]
    {
        S_IDLE  = 22'h000001,
        S_RD0   = 22'h000002,
        S_CHK0  = 22'h000004,
        S_RDN   = 22'h000008,
        S_CHKN  = 22'h000010,
        S_SRD   = 22'h000020,
        S_SCMP  = 22'h000040,
        S_GETU  = 22'h000080,
        S_GETL  = 22'h000100,
        S_IMUL  = 22'h000200,
        S_IDIV0 = 22'h000400,
        S_IWAIT = 22'h000800,
        S_ADDS  = 22'h001000,
        S_XMUL  = 22'h002000,
        S_TCHK  = 22'h004000,
        S_KRED  = 22'h008000,
        S_TINIT = 22'h010000,
        S_TMUL  = 22'h020000,
        S_TDIV0 = 22'h040000,
        S_TWAIT = 22'h080000,
        S_FIN   = 22'h100000,
        S_OUT   = 22'h200000
    } state_t;

    localparam logic signed [64:0] T_HI = 65'sh0_0020_0000_0000_0000;
    localparam logic signed [64:0] T_LO = -65'sh0_0200_0000_0000_0000;
    localparam logic [4:0] TN_DONE = 5'(TAYLOR_TERMS + 1);

    state_t state_reg, state_next;

    logic [6:0]  num_points_reg;
    logic        m_valid_reg;
    logic [31:0] m_disc_reg;
    logic [31:0] m_rate_reg;
    logic        m_sat_reg;

    logic [63:0] curve_mem [MAX_POINTS];
    logic [63:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;
    logic        wr_en;
    logic [31:0] wr_idx32;

    logic        s_accept;
    logic        q_accept;
    logic [5:0]  in_point_index;
    logic [31:0] in_point_time;
    logic [31:0] in_point_rate;
    logic [31:0] in_query_time;
    logic [31:0] in_rate_shift;

    logic [31:0] q_reg;
    logic [31:0] shift_reg;
    logic [AW-1:0] nm1_reg;
    logic [AW-1:0] lo_reg;
    logic [AW-1:0] hi_reg;
    logic [AW-1:0] mid_reg;
    logic [AW:0]   mid_sum;
    logic [31:0] neff32;

    logic [31:0] tu_reg;
    logic [31:0] ru_reg;
    logic [31:0] rl_reg;
    logic [31:0] d_reg;
    logic [31:0] e_reg;
    logic [32:0] mag_reg;
    logic        neg_reg;
    logic [64:0] prod_reg;
    logic [31:0] rate_reg;

    logic [31:0] rd_time;
    logic [31:0] rd_rate;
    logic [31:0] e_raw;
    logic signed [32:0] diff_s;
    logic signed [32:0] sum_s;

    logic [31:0] sr_reg;
    logic        sat_reg;
    logic signed [64:0] x_w;
    logic signed [64:0] t_reg;
    logic [57:0] red_reg;
    logic [57:0] ln2_sh;
    logic [5:0]  kq_reg;
    logic [2:0]  kj_reg;

    logic [63:0]  term_reg;
    logic [63:0]  sum_reg;
    logic [63:0]  r62_reg;
    logic [127:0] acc_reg;
    logic [1:0]   pp_reg;
    logic [4:0]   tn_reg;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pprod;
    logic [127:0] pshift;

    logic [6:0]  sh_amt;
    logic [64:0] rnd;
    logic [64:0] val;
    logic [31:0] disc_reg;

    cdf_div_req_t div_req;
    logic         div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    assign in_point_index = s_axis_tdata[5:0];
    assign in_point_time  = s_axis_tdata[37:6];
    assign in_point_rate  = s_axis_tdata[69:38];
    assign in_query_time  = s_axis_tdata[101:70];
    assign in_rate_shift  = s_axis_tdata[133:102];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign q_accept      = s_accept && (s_axis_tuser[0] == OP_QUERY);

    assign pready = 1'b1;
    assign prdata = (paddr == REG_NUM_POINTS) ? {25'd0, num_points_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NUM_POINTS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_NUM_POINTS)
        begin
            num_points_reg <= pwdata[6:0];
        end
    end

    always_comb
    begin
        if (num_points_reg == 7'd0)
        begin
            neff32 = 32'd1;
        end
        else if (32'(num_points_reg) > 32'(MAX_POINTS))
        begin
            neff32 = 32'(MAX_POINTS);
        end
        else
        begin
            neff32 = 32'(num_points_reg);
        end
    end

    assign wr_idx32 = 32'(in_point_index);
    assign wr_en    = s_accept && (s_axis_tuser[0] == OP_LOAD) && (wr_idx32 < 32'(MAX_POINTS));
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            S_RD0:
            begin
                rd_en = 1'b1;
            end
            S_RDN:
            begin
                rd_en   = 1'b1;
                rd_addr = nm1_reg;
            end
            S_SRD:
            begin
                rd_en   = 1'b1;
                rd_addr = (lo_reg < hi_reg) ? mid_sum[AW:1] : lo_reg;
            end
            S_GETU:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg - AW'(1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_idx32[AW-1:0]] <= {in_point_rate, in_point_time};
        end
        if (rd_en)
        begin
            rd_data_reg <= curve_mem[rd_addr];
        end
    end

    assign rd_time = rd_data_reg[31:0];
    assign rd_rate = rd_data_reg[63:32];

    assign e_raw  = (q_reg < rd_time) ? 32'd0 :
                    ((q_reg - rd_time) > (tu_reg - rd_time)) ? (tu_reg - rd_time) :
                    (q_reg - rd_time);
    assign diff_s = $signed({ru_reg[31], ru_reg}) - $signed({rd_rate[31], rd_rate});
    assign sum_s  = $signed({rate_reg[31], rate_reg}) + $signed({shift_reg[31], shift_reg});
    assign x_w    = $signed(sr_reg) * $signed({1'b0, q_reg});
    assign ln2_sh = 58'(LN2_Q52) << kj_reg;

    assign pa     = pp_reg[1] ? term_reg[63:32] : term_reg[31:0];
    assign pb     = pp_reg[0] ? r62_reg[63:32] : r62_reg[31:0];
    assign pprod  = pa * pb;

    always_comb
    begin
        case (pp_reg)
            2'd0:    pshift = {64'd0, pprod};
            2'd3:    pshift = {pprod, 64'd0};
            default: pshift = {32'd0, pprod, 32'd0};
        endcase
    end

    assign sh_amt = SHIFT_BASE - 7'(kq_reg);
    assign rnd    = 65'(sum_reg) + (65'd1 << (sh_amt - 7'd1));
    assign val    = rnd >> sh_amt;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg + 65'(d_reg >> 1);
        div_req.divisor  = 33'(d_reg);
        if (state_reg == S_IDIV0)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_TDIV0)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = 65'(acc_reg[125:62]);
            div_req.divisor  = 33'(tn_reg);
        end
    end

    cdf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept && s_axis_tuser[0] == OP_QUERY)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:   state_next = S_CHK0;
            S_CHK0:  state_next = (q_reg <= rd_time) ? S_ADDS : S_RDN;
            S_RDN:   state_next = S_CHKN;
            S_CHKN:  state_next = (q_reg >= rd_time) ? S_ADDS : S_SRD;
            S_SRD:   state_next = (lo_reg < hi_reg) ? S_SCMP : S_GETU;
            S_SCMP:  state_next = S_SRD;
            S_GETU:  state_next = S_GETL;
            S_GETL:  state_next = (tu_reg <= rd_time) ? S_ADDS : S_IMUL;
            S_IMUL:  state_next = S_IDIV0;
            S_IDIV0: state_next = S_IWAIT;
            S_IWAIT: state_next = div_done ? S_ADDS : S_IWAIT;
            S_ADDS:  state_next = S_XMUL;
            S_XMUL:  state_next = S_TCHK;
            S_TCHK:  state_next = (t_reg > T_HI || t_reg < T_LO) ? S_OUT : S_KRED;
            S_KRED:  state_next = (kj_reg == 3'd0) ? S_TINIT : S_KRED;
            S_TINIT: state_next = S_TMUL;
            S_TMUL:  state_next = (pp_reg == 2'd3) ? S_TDIV0 : S_TMUL;
            S_TDIV0: state_next = S_TWAIT;
            S_TWAIT:
            begin
                if (div_done)
                begin
                    state_next = (tn_reg == 5'(TAYLOR_TERMS)) ? S_FIN : S_TMUL;
                end
            end
            S_FIN:   state_next = S_OUT;
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                q_reg     <= in_query_time;
                shift_reg <= in_rate_shift;
                nm1_reg   <= AW'(neff32 - 32'd1);
                sat_reg   <= 1'b0;
            end
            S_CHK0:
            begin
                rate_reg <= rd_rate;
            end
            S_CHKN:
            begin
                rate_reg <= rd_rate;
                lo_reg   <= AW'(1);
                hi_reg   <= nm1_reg;
            end
            S_SRD:
            begin
                mid_reg <= mid_sum[AW:1];
            end
            S_SCMP:
            begin
                if (rd_time > q_reg)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + AW'(1);
                end
            end
            S_GETU:
            begin
                tu_reg <= rd_time;
                ru_reg <= rd_rate;
            end
            S_GETL:
            begin
                rate_reg <= rd_rate;
                rl_reg   <= rd_rate;
                d_reg    <= tu_reg - rd_time;
                e_reg    <= e_raw;
                neg_reg  <= diff_s < 0;
                mag_reg  <= (diff_s < 0) ? 33'(-diff_s) : 33'(diff_s);
            end
            S_IMUL:
            begin
                prod_reg <= e_reg * mag_reg;
            end
            S_IWAIT:
            begin
                if (div_done)
                begin
                    rate_reg <= neg_reg ? (rl_reg - div_quo[31:0]) : (rl_reg + div_quo[31:0]);
                end
            end
            S_ADDS:
            begin
                if (sum_s[32] != sum_s[31])
                begin
                    sat_reg <= 1'b1;
                    sr_reg  <= sum_s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    sr_reg <= sum_s[31:0];
                end
            end
            S_XMUL:
            begin
                t_reg <= -x_w;
            end
            S_TCHK:
            begin
                red_reg <= 58'(t_reg + 65'(BIAS_LN2));
                kq_reg  <= '0;
                kj_reg  <= 3'd5;
                if (t_reg > T_HI)
                begin
                    sat_reg  <= 1'b1;
                    disc_reg <= 32'hFFFF_FFFF;
                end
                else
                begin
                    disc_reg <= 32'd0;
                end
            end
            S_KRED:
            begin
                if (red_reg >= ln2_sh)
                begin
                    red_reg         <= red_reg - ln2_sh;
                    kq_reg[kj_reg]  <= 1'b1;
                end
                kj_reg <= kj_reg - 3'd1;
            end
            S_TINIT:
            begin
                r62_reg  <= 64'(red_reg) << 10;
                term_reg <= 64'h4000_0000_0000_0000;
                sum_reg  <= 64'h4000_0000_0000_0000;
                tn_reg   <= 5'd1;
                pp_reg   <= 2'd0;
                acc_reg  <= '0;
            end
            S_TMUL:
            begin
                acc_reg <= acc_reg + pshift;
                pp_reg  <= pp_reg + 2'd1;
            end
            S_TWAIT:
            begin
                if (div_done)
                begin
                    term_reg <= div_quo[63:0];
                    sum_reg  <= sum_reg + div_quo[63:0];
                    acc_reg  <= '0;
                    tn_reg   <= tn_reg + 5'd1;
                end
            end
            S_FIN:
            begin
                if (sh_amt >= 7'd64)
                begin
                    disc_reg <= 32'd0;
                end
                else if (val > 65'h0_FFFF_FFFF)
                begin
                    disc_reg <= 32'hFFFF_FFFF;
                    sat_reg  <= 1'b1;
                end
                else
                begin
                    disc_reg <= val[31:0];
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_disc_reg <= disc_reg;
                    m_rate_reg <= sr_reg;
                    m_sat_reg  <= sat_reg;
                end
            end
            default:
            begin
                pp_reg <= pp_reg;
            end
        endcase
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {m_rate_reg, m_disc_reg};
    assign m_axis_tuser[0] = m_sat_reg;

    `CDF_ASSERT(a_query_starts, clk, rst_n, q_accept |=> state_reg == S_RD0, "no lookup")
    `CDF_ASSERT(a_search_bounds, clk, rst_n, state_reg == S_SRD |-> lo_reg <= hi_reg, "bad bounds")
    `CDF_ASSERT(a_taylor_count, clk, rst_n, state_reg == S_FIN |-> tn_reg == TN_DONE, "short series")
    `CDF_ASSERT(a_out_load, clk, rst_n, $rose(m_valid_reg) |-> $past(state_reg == S_OUT), "bad beat")

endmodule
